FILE: sv/sppwm_pkg.sv
// Shared types, constants and codes of the servo PI/PWM block with overcurrent guard.
`default_nettype none

package sppwm_pkg;

    // Fixed-point and window configuration
    localparam int FRAC_BITS     = 8;
    localparam int WINDOW_LENGTH = 16;
    localparam int PTR_W         = $clog2(WINDOW_LENGTH);

    // Field widths
    localparam int D_W      = 24;
    localparam int M_W      = 16;
    localparam int C_W      = 16;
    localparam int PWM_W    = 13;
    localparam int STATUS_W = 2;
    localparam int SUM_W    = 24;
    localparam int ALG_W    = 2;
    localparam int SET_W    = 2;
    localparam int A_W      = 16;
    localparam int B_W      = 24;
    localparam int LIM_W    = 12;
    localparam int CSL_W    = 24;
    localparam int PER_W    = 20;
    localparam int TICK_W   = 32;
    localparam int DE_W     = 32;

    // Configuration port
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_ALGORITHM_SELECT     = 3'd0;
    localparam logic [IDX_W-1:0] REG_PARAMETER_SET_SELECT = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFF_A              = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEFF_B0             = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEFF_B1             = 3'd4;
    localparam logic [IDX_W-1:0] REG_PWM_LIMIT            = 3'd5;
    localparam logic [IDX_W-1:0] REG_CURRENT_SUM_LIMIT    = 3'd6;
    localparam logic [IDX_W-1:0] REG_BLOCKED_PERIOD       = 3'd7;

    // Register reset values
    localparam logic [A_W-1:0]   COEFF_A_RST           = 16'd13107;
    localparam logic [B_W-1:0]   COEFF_B0_RST          = 24'd1047552;
    localparam logic [B_W-1:0]   COEFF_B1_RST          = 24'd1034445;
    localparam logic [LIM_W-1:0] PWM_LIMIT_RST         = 12'd1000;
    localparam logic [CSL_W-1:0] CURRENT_SUM_LIMIT_RST = 24'd100000;
    localparam logic [PER_W-1:0] BLOCKED_PERIOD_RST    = 20'd1000;

    // Algorithm and parameter-set codes
    localparam logic [ALG_W-1:0] ALG_PDI   = 2'd0;
    localparam logic [ALG_W-1:0] ALG_CONST = 2'd1;
    localparam logic [SET_W-1:0] SET_ZERO  = 2'd0;
    localparam logic [SET_W-1:0] SET_LAST  = 2'd1;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SET = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ALG = 2'd2;

    // Input beat
    typedef struct packed {
        logic signed [D_W-1:0] desired_increment;
        logic signed [M_W-1:0] measured_increment;
        logic signed [C_W-1:0] motor_current;
    } item_t;

    // Result beat
    typedef struct packed {
        logic signed [PWM_W-1:0]    pwm_duty;
        logic        [STATUS_W-1:0] status;
        logic                       gripper_blocked;
        logic signed [SUM_W-1:0]    current_window_sum;
    } result_t;

    // Sequencer strobes, one per phase of a tick
    typedef struct packed {
        logic start;
        logic ring;
        logic de;
        logic mul;
        logic sum;
        logic fin;
    } step_t;

    // Settings and selection state seen by the datapath
    typedef struct packed {
        logic [A_W-1:0]      coeff_a;
        logic [B_W-1:0]      coeff_b0;
        logic [B_W-1:0]      coeff_b1;
        logic [LIM_W-1:0]    pwm_limit;
        logic [CSL_W-1:0]    current_sum_limit;
        logic [PER_W-1:0]    blocked_period;
        logic [ALG_W-1:0]    active_algorithm;
        logic [STATUS_W-1:0] status;
    } cfg_t;

    // Guard outputs for the current tick
    typedef struct packed {
        logic                    blocked;
        logic                    clear_hist;
        logic signed [SUM_W-1:0] window_sum;
    } guard_t;

endpackage

`default_nettype wire

FILE: sv/servo_pi_pwm_with_overcurrent_guard.sv
// Top level: tick sequencer and result register of the servo PI/PWM block.
//
// One input beat per servo tick carries desired_increment, measured_increment
// and motor_current on item/item_valid; item_stall is driven by the block.
// One result beat per tick leaves on result/result_valid with pwm_duty,
// status, gripper_blocked and current_window_sum; the receiver holds it with
// result_stall.
// A tick runs through six phases of a sequencer: accept and read the current
// ring RAM, error products and ring write-back, integral increment, four law
// products, law sum, then clamp and result. A new beat is taken only once the
// previous tick has left its last phase; the chained products and the single
// read port of the ring RAM are why the phases run one after another.
// The result register frees the sequencer: the next beat is accepted while
// a result still waits; a tick that finishes while the earlier result is
// still held waits in its last phase until the receiver takes that beat.
// Reset clears the loop history, the window sum, the guard (start state),
// the tick count and the active algorithm and parameter set; the settings
// return to their reset values. Configuration goes through the APB port.
`default_nettype none

module servo_pi_pwm_with_overcurrent_guard
    import sppwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RING,
        S_DE,
        S_MUL,
        S_SUM,
        S_FIN
    } state_t;

    state_t                  state_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;

    step_t                   step;
    cfg_t                    cfg;
    guard_t                  guard;
    logic signed [PWM_W-1:0] pwm_duty;
    logic                    out_free;

    assign out_free   = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE);

    // Phase strobes
    assign step.start = item_valid && (state_reg == S_IDLE);
    assign step.ring  = (state_reg == S_RING);
    assign step.de    = (state_reg == S_DE);
    assign step.mul   = (state_reg == S_MUL);
    assign step.sum   = (state_reg == S_SUM);
    assign step.fin   = (state_reg == S_FIN) && out_free;

    sppwm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .step    (step),
        .cfg     (cfg)
    );

    sppwm_guard u_guard (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .motor_current (item.motor_current),
        .cfg           (cfg),
        .guard         (guard)
    );

    sppwm_loop u_loop (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .desired_increment  (item.desired_increment),
        .measured_increment (item.measured_increment),
        .cfg                (cfg),
        .clear_hist         (guard.clear_hist),
        .pwm_duty           (pwm_duty)
    );

    // Sequence the tick and hold the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && !step.fin)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_RING;
                    end
                end
                S_RING:  state_reg <= S_DE;
                S_DE:    state_reg <= S_MUL;
                S_MUL:   state_reg <= S_SUM;
                S_SUM:   state_reg <= S_FIN;
                S_FIN:
                begin
                    if (out_free)
                    begin
                        result_valid_reg              <= 1'b1;
                        result_reg.pwm_duty           <= pwm_duty;
                        result_reg.status             <= cfg.status;
                        result_reg.gripper_blocked    <= guard.blocked;
                        result_reg.current_window_sum <= guard.window_sum;
                        state_reg                     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: sv/sppwm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module sppwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry and read one entry; the read data is registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/sppwm_cfg.sv
// Configuration registers and algorithm / parameter-set selection.
`default_nettype none

module sppwm_cfg
    import sppwm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire step_t             step,
    output cfg_t                   cfg
);

    logic [ALG_W-1:0]    alg_sel_reg;
    logic [SET_W-1:0]    set_sel_reg;
    logic [A_W-1:0]      coeff_a_reg;
    logic [B_W-1:0]      coeff_b0_reg;
    logic [B_W-1:0]      coeff_b1_reg;
    logic [LIM_W-1:0]    pwm_limit_reg;
    logic [CSL_W-1:0]    csl_reg;
    logic [PER_W-1:0]    period_reg;
    logic [ALG_W-1:0]    active_alg_reg;
    logic [SET_W-1:0]    active_set_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;

    logic                wr_en;
    logic [IDX_W-1:0]    idx;
    logic                changed;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    // Check a changed request against the valid codes
    assign changed = (active_alg_reg != alg_sel_reg) || (active_set_reg != set_sel_reg);

    always_comb
    begin
        status_next = STATUS_OK;
        if (changed)
        begin
            priority if (alg_sel_reg > ALG_CONST)
            begin
                status_next = STATUS_BAD_ALG;
            end
            else if (set_sel_reg > SET_LAST)
            begin
                status_next = STATUS_BAD_SET;
            end
            else
            begin
                status_next = STATUS_OK;
            end
        end
    end

    // Hold registers; apply writes and the per-tick selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alg_sel_reg    <= ALG_PDI;
            set_sel_reg    <= SET_ZERO;
            coeff_a_reg    <= COEFF_A_RST;
            coeff_b0_reg   <= COEFF_B0_RST;
            coeff_b1_reg   <= COEFF_B1_RST;
            pwm_limit_reg  <= PWM_LIMIT_RST;
            csl_reg        <= CURRENT_SUM_LIMIT_RST;
            period_reg     <= BLOCKED_PERIOD_RST;
            active_alg_reg <= ALG_PDI;
            active_set_reg <= SET_ZERO;
            status_reg     <= STATUS_OK;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_ALGORITHM_SELECT:     alg_sel_reg   <= pwdata[ALG_W-1:0];
                REG_PARAMETER_SET_SELECT: set_sel_reg   <= pwdata[SET_W-1:0];
                REG_COEFF_A:              coeff_a_reg   <= pwdata[A_W-1:0];
                REG_COEFF_B0:             coeff_b0_reg  <= pwdata[B_W-1:0];
                REG_COEFF_B1:             coeff_b1_reg  <= pwdata[B_W-1:0];
                REG_PWM_LIMIT:            pwm_limit_reg <= pwdata[LIM_W-1:0];
                REG_CURRENT_SUM_LIMIT:    csl_reg       <= pwdata[CSL_W-1:0];
                REG_BLOCKED_PERIOD:       period_reg    <= pwdata[PER_W-1:0];
                default:                  ;
            endcase
        end
        else if (step.start)
        begin
            status_reg <= status_next;
            if (changed)
            begin
                if (status_next == STATUS_OK)
                begin
                    active_alg_reg <= alg_sel_reg;
                    active_set_reg <= set_sel_reg;
                end
                else
                begin
                    // Revert the request to the last valid pair
                    alg_sel_reg <= active_alg_reg;
                    set_sel_reg <= active_set_reg;
                end
            end
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_ALGORITHM_SELECT:     prdata = DATA_W'(alg_sel_reg);
            REG_PARAMETER_SET_SELECT: prdata = DATA_W'(set_sel_reg);
            REG_COEFF_A:              prdata = DATA_W'(coeff_a_reg);
            REG_COEFF_B0:             prdata = DATA_W'(coeff_b0_reg);
            REG_COEFF_B1:             prdata = DATA_W'(coeff_b1_reg);
            REG_PWM_LIMIT:            prdata = DATA_W'(pwm_limit_reg);
            REG_CURRENT_SUM_LIMIT:    prdata = DATA_W'(csl_reg);
            REG_BLOCKED_PERIOD:       prdata = DATA_W'(period_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cfg.coeff_a           = coeff_a_reg;
    assign cfg.coeff_b0          = coeff_b0_reg;
    assign cfg.coeff_b1          = coeff_b1_reg;
    assign cfg.pwm_limit         = pwm_limit_reg;
    assign cfg.current_sum_limit = csl_reg;
    assign cfg.blocked_period    = period_reg;
    assign cfg.active_algorithm  = active_alg_reg;
    assign cfg.status            = status_reg;

endmodule

`default_nettype wire

FILE: sv/sppwm_guard.sv
// Current window over a ring RAM and the start/blocked overcurrent guard.
`default_nettype none

module sppwm_guard
    import sppwm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire step_t                step,
    input  wire logic signed [C_W-1:0] motor_current,
    input  wire cfg_t                 cfg,
    output guard_t                    guard
);

    typedef enum logic {
        GUARD_START,
        GUARD_BLOCKED
    } guard_state_t;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LENGTH - 1);

    guard_state_t             next_state_reg;
    logic signed [C_W-1:0]    cur_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic                     wrapped_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [TICK_W-1:0]        tick_reg;
    logic [TICK_W-1:0]        since_reg;
    logic                     blocked_reg;
    logic                     clear_reg;

    logic [C_W-1:0]           rd_data;
    logic signed [C_W-1:0]    old_sample;
    logic signed [SUM_W-1:0]  sum_next;
    logic [TICK_W-1:0]        elapsed;
    logic                     over;
    logic                     release_ok;

    // Ring of current samples: read at accept, write back the new one in the ring phase
    sppwm_ram #(
        .WIDTH (C_W),
        .DEPTH (WINDOW_LENGTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (step.ring),
        .wr_addr (ptr_reg),
        .wr_data (cur_reg),
        .rd_en   (step.start),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Entries not yet written since reset read as zero
    assign old_sample = wrapped_reg ? $signed(rd_data) : '0;

    assign sum_next = sum_reg - SUM_W'(old_sample) + SUM_W'(cur_reg);
    assign over     = $signed({sum_next[SUM_W-1], sum_next}) >
                      $signed({1'b0, cfg.current_sum_limit});
    assign elapsed  = tick_reg - since_reg;
    assign release_ok = (elapsed > TICK_W'(cfg.blocked_period)) && !over;

    // Advance the window and the guard once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_state_reg <= GUARD_START;
            cur_reg        <= '0;
            ptr_reg        <= '0;
            wrapped_reg    <= 1'b0;
            sum_reg        <= '0;
            tick_reg       <= '0;
            since_reg      <= '0;
            blocked_reg    <= 1'b0;
            clear_reg      <= 1'b0;
        end
        else
        begin
            if (step.start)
            begin
                cur_reg  <= motor_current;
                tick_reg <= tick_reg + TICK_W'(1);
            end
            if (step.ring)
            begin
                sum_reg <= sum_next;
                if (ptr_reg == PTR_LAST)
                begin
                    ptr_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end
                blocked_reg <= (next_state_reg == GUARD_BLOCKED);
                unique case (next_state_reg)
                    GUARD_START:
                    begin
                        clear_reg <= 1'b0;
                        if (over)
                        begin
                            next_state_reg <= GUARD_BLOCKED;
                            since_reg      <= tick_reg;
                        end
                    end
                    GUARD_BLOCKED:
                    begin
                        if (release_ok)
                        begin
                            next_state_reg <= GUARD_START;
                            clear_reg      <= 1'b0;
                        end
                        else
                        begin
                            clear_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        next_state_reg <= GUARD_START;
                    end
                endcase
            end
        end
    end

    assign guard.blocked    = blocked_reg;
    assign guard.clear_hist = clear_reg;
    assign guard.window_sum = sum_reg;

endmodule

`default_nettype wire

FILE: sv/sppwm_loop.sv
// Incremental PD+I control law: error integral increment, duty, clamp and history.
`default_nettype none

module sppwm_loop
    import sppwm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire step_t                  step,
    input  wire logic signed [D_W-1:0]  desired_increment,
    input  wire logic signed [M_W-1:0]  measured_increment,
    input  wire cfg_t                   cfg,
    input  wire logic                   clear_hist,
    output logic signed [PWM_W-1:0]     pwm_duty
);

    // Datapath widths
    localparam int ERR_W = ((D_W > M_W + FRAC_BITS) ? D_W : M_W + FRAC_BITS) + 1;
    localparam int G_W   = 18;
    localparam int PE_W  = ERR_W + G_W;
    localparam int A1_W  = ((DE_W + 16 > PE_W) ? DE_W + 16 : PE_W) + 2;
    localparam int U_W   = LIM_W + FRAC_BITS + 1;
    localparam int QA_W  = U_W + A_W + 2;
    localparam int QB_W  = DE_W + B_W + 1;
    localparam int Q_W   = (QA_W > QB_W) ? QA_W : QB_W;
    localparam int A2_W  = Q_W + 2;
    localparam int UF_W  = A2_W - 16;

    localparam logic signed [G_W-1:0]  GAIN_NEW   = 18'sd66847;
    localparam logic signed [G_W-1:0]  GAIN_OLD   = 18'sd64225;
    localparam logic signed [A1_W-1:0] HALF1      = A1_W'(32768);
    localparam logic signed [A2_W-1:0] HALF2      = A2_W'(32768);
    localparam logic signed [A1_W-1:0] DE_MAX     = (A1_W'(1) <<< (DE_W - 1)) - A1_W'(1);
    localparam logic signed [A1_W-1:0] DE_MIN     = -(A1_W'(1) <<< (DE_W - 1));
    localparam logic signed [UF_W-1:0] CONST_DUTY = UF_W'(50) <<< FRAC_BITS;

    // Tick inputs
    logic signed [D_W-1:0]   d_reg;
    logic signed [M_W-1:0]   m_reg;

    // Loop history
    logic signed [M_W-1:0]   pm_reg;
    logic signed [D_W-1:0]   pd_reg;
    logic signed [DE_W-1:0]  pi_reg;
    logic signed [U_W-1:0]   h1_reg;
    logic signed [U_W-1:0]   h2_reg;

    // Pipeline registers
    logic signed [PE_W-1:0]  pn_reg;
    logic signed [PE_W-1:0]  po_reg;
    logic signed [DE_W-1:0]  de_reg;
    logic signed [Q_W-1:0]   q1_reg;
    logic signed [Q_W-1:0]   q2_reg;
    logic signed [Q_W-1:0]   q3_reg;
    logic signed [Q_W-1:0]   q4_reg;
    logic signed [UF_W-1:0]  uf_reg;

    logic signed [ERR_W-1:0] e_new;
    logic signed [ERR_W-1:0] e_old;
    logic signed [A1_W-1:0]  acc1;
    logic signed [A1_W-1:0]  r1;
    logic signed [DE_W-1:0]  de_next;
    logic signed [G_W-1:0]   pole_one;
    logic signed [G_W-1:0]   pole;
    logic signed [Q_W-1:0]   b0_s;
    logic signed [Q_W-1:0]   b1_s;
    logic signed [A2_W-1:0]  acc2;
    logic signed [UF_W-1:0]  lim;
    logic signed [UF_W-1:0]  u_raw;
    logic signed [UF_W-1:0]  u_clamp;
    logic signed [U_W-1:0]   u_next;
    logic signed [U_W-1:0]   u_mag;

    // Position errors at the fixed-point scale
    assign e_new = ERR_W'(d_reg) - (ERR_W'(m_reg) <<< FRAC_BITS);
    assign e_old = ERR_W'(pd_reg) - (ERR_W'(pm_reg) <<< FRAC_BITS);

    // Integral increment: round half up, saturate to 32 bits
    assign acc1 = (A1_W'(pi_reg) <<< 16) + A1_W'(pn_reg) - A1_W'(po_reg) + HALF1;
    assign r1   = acc1 >>> 16;

    always_comb
    begin
        priority if (r1 > DE_MAX)
        begin
            de_next = DE_W'(DE_MAX);
        end
        else if (r1 < DE_MIN)
        begin
            de_next = DE_W'(DE_MIN);
        end
        else
        begin
            de_next = DE_W'(r1);
        end
    end

    // Coefficients as signed operands
    assign pole_one = $signed({2'b01, cfg.coeff_a});
    assign pole     = $signed({2'b00, cfg.coeff_a});
    assign b0_s     = Q_W'($signed({1'b0, cfg.coeff_b0}));
    assign b1_s     = Q_W'($signed({1'b0, cfg.coeff_b1}));

    // Sum the law terms and round back to the duty scale
    assign acc2 = A2_W'(q1_reg) - A2_W'(q2_reg) + A2_W'(q3_reg) - A2_W'(q4_reg) + HALF2;

    // Select the algorithm and clamp to the duty limit
    assign lim = UF_W'($signed({1'b0, cfg.pwm_limit})) <<< FRAC_BITS;

    always_comb
    begin
        unique case (cfg.active_algorithm)
            ALG_PDI:   u_raw = uf_reg;
            ALG_CONST: u_raw = CONST_DUTY;
            default:   u_raw = '0;
        endcase
    end

    always_comb
    begin
        priority if (u_raw > lim)
        begin
            u_clamp = lim;
        end
        else if (u_raw < -lim)
        begin
            u_clamp = -lim;
        end
        else
        begin
            u_clamp = u_raw;
        end
    end

    assign u_next = U_W'(u_clamp);

    // Drop the fraction, truncating toward zero
    assign u_mag = u_next[U_W-1] ? -u_next : u_next;

    always_comb
    begin
        if (u_next[U_W-1])
        begin
            pwm_duty = -PWM_W'(u_mag >>> FRAC_BITS);
        end
        else
        begin
            pwm_duty = PWM_W'(u_mag >>> FRAC_BITS);
        end
    end

    // Step through the phases of a tick; update or clear the history when the result leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg <= '0;
            pd_reg <= '0;
            pi_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
        end
        else if (step.fin)
        begin
            if (clear_hist)
            begin
                pm_reg <= '0;
                pd_reg <= '0;
                pi_reg <= '0;
                h1_reg <= '0;
                h2_reg <= '0;
            end
            else
            begin
                pm_reg <= m_reg;
                pd_reg <= d_reg;
                pi_reg <= de_reg;
                h2_reg <= h1_reg;
                h1_reg <= u_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.start)
        begin
            d_reg <= desired_increment;
            m_reg <= measured_increment;
        end
        if (step.ring)
        begin
            pn_reg <= PE_W'(e_new) * PE_W'(GAIN_NEW);
            po_reg <= PE_W'(e_old) * PE_W'(GAIN_OLD);
        end
        if (step.de)
        begin
            de_reg <= de_next;
        end
        if (step.mul)
        begin
            q1_reg <= Q_W'(h1_reg) * Q_W'(pole_one);
            q2_reg <= Q_W'(h2_reg) * Q_W'(pole);
            q3_reg <= Q_W'(de_reg) * b0_s;
            q4_reg <= Q_W'(pi_reg) * b1_s;
        end
        if (step.sum)
        begin
            uf_reg <= UF_W'(acc2 >>> 16);
        end
    end

endmodule

`default_nettype wire

FILE: sim/servo_pi_pwm_with_overcurrent_guard_test.sv
// Self-checking testbench for the servo PI/PWM block with overcurrent guard.
`default_nettype none

module servo_pi_pwm_with_overcurrent_guard_test
    import sppwm_pkg::*;
();

    localparam int CLK_HI        = 6;
    localparam int CLK_LO        = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int WINDUP_ITEMS  = 40;

    localparam int D_MAX = 8388607;
    localparam int D_MIN = -8388608;
    localparam int M_MAX = 32767;
    localparam int M_MIN = -32768;
    localparam int C_MAX = 32767;
    localparam int C_MIN = -32768;

    // Selection codes that the block must refuse
    localparam logic [ALG_W-1:0] ALG_UNDEFINED = 2'd3;
    localparam logic [SET_W-1:0] SET_UNDEFINED = 2'd2;

    // Fixed-point constants of the control law
    localparam longint Q_ONE         = longint'(1) << FRAC_BITS;
    localparam longint Q16_ONE       = 65536;
    localparam longint HALF_Q16      = 32768;
    localparam longint ERR_GAIN_NOW  = 66847;
    localparam longint ERR_GAIN_PAST = 64225;
    localparam longint CONST_DUTY    = 50;
    localparam longint DE_MAX        = (longint'(1) << (DE_W - 1)) - 1;
    localparam longint DE_MIN        = -(longint'(1) << (DE_W - 1));

    typedef enum logic {GUARD_START, GUARD_BLOCKED} tick_guard_t;

    // Servo tick predictor and queue of the duty results still owed
    class servo_tick_board_t;
        logic [ALG_W-1:0] alg_req;
        logic [ALG_W-1:0] alg_act;
        logic [SET_W-1:0] set_req;
        logic [SET_W-1:0] set_act;
        longint coeff_a;
        longint coeff_b0;
        longint coeff_b1;
        longint duty_limit;
        longint sum_limit;
        longint hold_period;
        longint last_meas;
        longint last_desired;
        longint last_de;
        longint duty_1;
        longint duty_2;
        longint ring [WINDOW_LENGTH];
        int ring_ptr;
        longint window_total;
        tick_guard_t guard_now;
        tick_guard_t guard_next;
        logic [TICK_W-1:0] tick_no;
        logic [TICK_W-1:0] blocked_at;
        result_t tick_results [$];
        int errors;

        function new();
            alg_req = ALG_PDI;
            alg_act = ALG_PDI;
            set_req = SET_ZERO;
            set_act = SET_ZERO;
            coeff_a = COEFF_A_RST;
            coeff_b0 = COEFF_B0_RST;
            coeff_b1 = COEFF_B1_RST;
            duty_limit = PWM_LIMIT_RST;
            sum_limit = CURRENT_SUM_LIMIT_RST;
            hold_period = BLOCKED_PERIOD_RST;
            last_meas = 0;
            last_desired = 0;
            last_de = 0;
            duty_1 = 0;
            duty_2 = 0;
            foreach (ring[i])
                ring[i] = 0;
            ring_ptr = 0;
            window_total = 0;
            guard_now = GUARD_START;
            guard_next = GUARD_START;
            tick_no = '0;
            blocked_at = '0;
            errors = 0;
        endfunction

        function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
            case (idx)
                REG_ALGORITHM_SELECT:     alg_req = v[ALG_W-1:0];
                REG_PARAMETER_SET_SELECT: set_req = v[SET_W-1:0];
                REG_COEFF_A:              coeff_a = longint'(v[A_W-1:0]);
                REG_COEFF_B0:             coeff_b0 = longint'(v[B_W-1:0]);
                REG_COEFF_B1:             coeff_b1 = longint'(v[B_W-1:0]);
                REG_PWM_LIMIT:            duty_limit = longint'(v[LIM_W-1:0]);
                REG_CURRENT_SUM_LIMIT:    sum_limit = longint'(v[CSL_W-1:0]);
                REG_BLOCKED_PERIOD:       hold_period = longint'(v[PER_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint round_q16(longint v);
            return (v + HALF_Q16) >>> 16;
        endfunction

        function int pending();
            return tick_results.size();
        endfunction

        // Run one servo tick and queue the result it owes
        function void predict_tick(item_t x);
            longint des;
            longint meas;
            longint cur;
            longint err_now;
            longint err_past;
            longint de;
            longint u;
            longint bound;
            longint duty;
            logic [STATUS_W-1:0] st;
            logic [TICK_W-1:0] elapsed;
            bit over;
            result_t r;

            tick_no = tick_no + 1'b1;
            des = longint'($signed(x.desired_increment));
            meas = longint'($signed(x.measured_increment));
            cur = longint'($signed(x.motor_current));

            // integral increment, saturated to 32 bits
            err_now = des - meas * Q_ONE;
            err_past = last_desired - last_meas * Q_ONE;
            de = round_q16(last_de * Q16_ONE + ERR_GAIN_NOW * err_now
                           - ERR_GAIN_PAST * err_past);
            if (de > DE_MAX)
                de = DE_MAX;
            if (de < DE_MIN)
                de = DE_MIN;

            // take a new selection or fall back to the active pair
            st = STATUS_OK;
            if (alg_act != alg_req || set_act != set_req)
            begin
                if (alg_req > ALG_CONST)
                    st = STATUS_BAD_ALG;
                else if (set_req > SET_LAST)
                    st = STATUS_BAD_SET;
                if (st == STATUS_OK)
                begin
                    alg_act = alg_req;
                    set_act = set_req;
                end
                else
                begin
                    alg_req = alg_act;
                    set_req = set_act;
                end
            end

            // duty law, clamp, truncate toward zero
            if (alg_act == ALG_PDI)
                u = round_q16((Q16_ONE + coeff_a) * duty_1 - coeff_a * duty_2
                              + coeff_b0 * de - coeff_b1 * last_de);
            else if (alg_act == ALG_CONST)
                u = CONST_DUTY * Q_ONE;
            else
                u = 0;
            bound = duty_limit * Q_ONE;
            if (u > bound)
                u = bound;
            if (u < -bound)
                u = -bound;
            duty = (u >= 0) ? (u >>> FRAC_BITS) : -((-u) >>> FRAC_BITS);

            last_meas = meas;
            last_de = de;
            last_desired = des;
            duty_2 = duty_1;
            duty_1 = u;

            // slide the current window
            window_total = window_total - ring[ring_ptr] + cur;
            ring[ring_ptr] = cur;
            ring_ptr = (ring_ptr + 1) % WINDOW_LENGTH;

            // guard: block on a high window, release after the period once low
            over = window_total > sum_limit;
            guard_now = guard_next;
            if (guard_now == GUARD_START)
            begin
                if (over)
                begin
                    guard_next = GUARD_BLOCKED;
                    blocked_at = tick_no;
                end
            end
            else
            begin
                elapsed = tick_no - blocked_at;
                if (longint'(elapsed) > hold_period && !over)
                    guard_next = GUARD_START;
                else
                begin
                    last_meas = 0;
                    last_de = 0;
                    last_desired = 0;
                    duty_1 = 0;
                    duty_2 = 0;
                end
            end

            r.pwm_duty = duty[PWM_W-1:0];
            r.status = st;
            r.gripper_blocked = (guard_now == GUARD_BLOCKED);
            r.current_window_sum = window_total[SUM_W-1:0];
            tick_results.push_back(r);
        endfunction

        // Compare a result beat with the oldest owed result
        function void compare_tick(result_t got);
            result_t want;
            if (tick_results.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = tick_results.pop_front();
            if (got.pwm_duty !== want.pwm_duty)
            begin
                $display("%0t pwm_duty mismatch: expected %0d, got %0d",
                         $time, want.pwm_duty, got.pwm_duty);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t status mismatch: expected %0d, got %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.gripper_blocked !== want.gripper_blocked)
            begin
                $display("%0t gripper_blocked mismatch: expected %0d, got %0d",
                         $time, want.gripper_blocked, got.gripper_blocked);
                errors++;
            end
            if (got.current_window_sum !== want.current_window_sum)
            begin
                $display("%0t current_window_sum mismatch: expected %0d, got %0d",
                         $time, want.current_window_sum, got.current_window_sum);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    bit tx_idle_ok = 1'b0;
    bit rx_idle_ok = 1'b0;
    bit long_hold_req = 1'b0;
    int surge_left = 0;
    int relief_left = 0;
    int unsigned cycles = 0;
    servo_tick_board_t board = new();

    servo_pi_pwm_with_overcurrent_guard dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #(CLK_LO) clk = 1'b1;
        #(CLK_HI) clk = 1'b0;
    end

    // Check every result beat taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.compare_tick(result);
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                result_stall <= 1'b0;
            end
            else if (rx_idle_ok && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    function automatic item_t item_of(input int des, input int meas, input int cur);
        item_t x;
        x.desired_increment = des[D_W-1:0];
        x.measured_increment = meas[M_W-1:0];
        x.motor_current = cur[C_W-1:0];
        return x;
    endfunction

    function automatic int unsigned pick_field(input int unsigned hi);
        case ($urandom_range(0, 7))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // Mostly servo-like ticks with current surges; some raw noise and extremes
    function automatic item_t random_item();
        logic [31:0] r1;
        logic [31:0] r2;
        int des;
        int meas;
        int cur;
        r1 = $urandom;
        r2 = $urandom;
        if (r2[2:0] == 0)
            return item_of(int'(r1[23:0]), int'(r2[31:16]), int'(r2[15:0]));
        des = int'($urandom_range(0, 8191)) - 4096;
        meas = int'($urandom_range(0, 32)) - 16;
        if (surge_left > 0)
        begin
            surge_left--;
            cur = 8000 + int'($urandom_range(0, 24767));
        end
        else if (relief_left > 0)
        begin
            relief_left--;
            cur = -8000 - int'($urandom_range(0, 24768));
        end
        else
        begin
            if ($urandom_range(0, 14) == 0)
            begin
                surge_left = $urandom_range(3, 12);
                relief_left = $urandom_range(3, 12);
            end
            cur = int'($urandom_range(0, 8000)) - 4000;
        end
        case (r2[7:4])
            0: des = r1[0] ? D_MAX : D_MIN;
            1: meas = r1[1] ? M_MAX : M_MIN;
            2: cur = r1[2] ? C_MAX : C_MIN;
            default: ;
        endcase
        return item_of(des, meas, cur);
    endfunction

    // Offer one beat, with an optional idle burst first; note it once taken
    task automatic send_item(input item_t x);
        if (tx_idle_ok && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clk);
        end
        @(negedge clk);
        item <= x;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        board.predict_tick(x);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_register(idx, v);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_random_settings();
        logic [31:0] r;
        logic [ALG_W-1:0] alg;
        logic [SET_W-1:0] pset;
        r = $urandom;
        alg = (r[2:0] == 0) ? r[5:4] : (r[6] ? ALG_CONST : ALG_PDI);
        pset = (r[10:8] == 0) ? r[13:12] : (r[14] ? SET_LAST : SET_ZERO);
        apb_write(REG_ALGORITHM_SELECT, alg);
        apb_write(REG_PARAMETER_SET_SELECT, pset);
        apb_write(REG_COEFF_A, pick_field(32'hFFFF));
        apb_write(REG_COEFF_B0, pick_field(r[16] ? 32'hFFFFFF : 32'h1FFFF));
        apb_write(REG_COEFF_B1, pick_field(r[17] ? 32'hFFFFFF : 32'h1FFFF));
        apb_write(REG_PWM_LIMIT, pick_field(32'hFFF));
        apb_write(REG_CURRENT_SUM_LIMIT,
                  r[18] ? pick_field(32'hFFFFFF) : $urandom_range(0, 150000));
        apb_write(REG_BLOCKED_PERIOD,
                  (r[21:19] == 0) ? pick_field(32'hFFFFF) : $urandom_range(0, 24));
    endtask

    // Drive a steady large error to push the integral increment far up
    task automatic drive_windup();
        apb_write(REG_ALGORITHM_SELECT, ALG_PDI);
        apb_write(REG_PARAMETER_SET_SELECT, SET_ZERO);
        apb_write(REG_CURRENT_SUM_LIMIT, 32'hFFFFFF);
        apb_write(REG_BLOCKED_PERIOD, 0);
        tx_idle_ok = 1'b0;
        rx_idle_ok = 1'b0;
        repeat (WINDUP_ITEMS)
            send_item(item_of(D_MAX - int'($urandom_range(0, 255)),
                              M_MIN + int'($urandom_range(0, 3)),
                              int'($urandom_range(0, 2000)) - 1000));
        settle();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        tx_idle_ok = 1'b1;
        rx_idle_ok = 1'b1;

        // field extremes under reset settings; four peak currents trip the guard
        send_item(item_of(0, 0, 0));
        send_item(item_of(D_MAX, M_MIN, 0));
        send_item(item_of(D_MIN, M_MAX, 0));
        send_item(item_of(D_MAX, M_MAX, C_MAX));
        send_item(item_of(D_MIN, M_MIN, C_MAX));
        send_item(item_of(0, 0, C_MAX));
        send_item(item_of(0, 0, C_MAX));
        send_item(item_of(123, -5, C_MIN));
        send_item(item_of(-1, 1, C_MIN));
        settle();

        // constant duty under a small bound; negative currents release the guard
        apb_write(REG_BLOCKED_PERIOD, 0);
        apb_write(REG_CURRENT_SUM_LIMIT, 0);
        apb_write(REG_PWM_LIMIT, 20);
        apb_write(REG_ALGORITHM_SELECT, ALG_CONST);
        repeat (3) send_item(item_of(0, 0, C_MIN));
        settle();

        // unknown algorithm reverts to the active one
        apb_write(REG_PWM_LIMIT, 32'hFFF);
        apb_write(REG_ALGORITHM_SELECT, ALG_UNDEFINED);
        repeat (2) send_item(item_of(-256, 1, 100));
        settle();

        // unknown parameter set with a valid algorithm
        apb_write(REG_ALGORITHM_SELECT, ALG_PDI);
        apb_write(REG_PARAMETER_SET_SELECT, SET_UNDEFINED);
        repeat (2) send_item(item_of(512, -1, -100));
        settle();

        // steepest pole, largest gain on the new increment, zero duty bound
        apb_write(REG_PARAMETER_SET_SELECT, SET_LAST);
        apb_write(REG_ALGORITHM_SELECT, ALG_PDI);
        apb_write(REG_COEFF_A, 32'hFFFF);
        apb_write(REG_COEFF_B0, 32'hFFFFFF);
        apb_write(REG_COEFF_B1, 0);
        apb_write(REG_PWM_LIMIT, 0);
        apb_write(REG_BLOCKED_PERIOD, 32'hFFFFF);
        apb_write(REG_CURRENT_SUM_LIMIT, 32'hFFFFFF);
        send_item(item_of(D_MAX, M_MIN, C_MIN));
        send_item(item_of(D_MIN, M_MAX, C_MAX));
        settle();

        // widest bound: saturate the duty both ways
        apb_write(REG_PWM_LIMIT, 32'hFFF);
        send_item(item_of(D_MAX, M_MIN, 0));
        send_item(item_of(D_MIN, M_MAX, 0));
        send_item(item_of(D_MIN, M_MAX, 0));
        settle();

        // no pole, all gain on the previous increment
        apb_write(REG_COEFF_A, 0);
        apb_write(REG_COEFF_B0, 0);
        apb_write(REG_COEFF_B1, 32'hFFFFFF);
        send_item(item_of(D_MAX, 0, 0));
        send_item(item_of(0, 0, 0));
        settle();

        // random phases; one long receiver hold-off, no idling in the last one
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_random_settings();
            tx_idle_ok = (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle_ok = (ph < RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == 2)
            begin
                tx_idle_ok = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_item(random_item());
            settle();
            if (ph == 1)
                drive_windup();
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/sppwm_pkg.sv
sv/sppwm_ram.sv
sv/sppwm_cfg.sv
sv/sppwm_guard.sv
sv/sppwm_loop.sv
sv/servo_pi_pwm_with_overcurrent_guard.sv
sim/servo_pi_pwm_with_overcurrent_guard_test.sv
